/* rtl/tcwc_pkg.sv */
`default_nettype none

package tcwc_pkg;

	localparam int IMAGE_SIZE_DEF = 512;
	localparam int PATCH_DIM_DEF  = 96;
	localparam int BORDER_DEF     = 24;
	localparam int FIFO_DEPTH     = 4;

	localparam int HEIGHT_W    = 16;
	localparam int CLASS_W     = 3;
	localparam int ORG_W       = 9;
	localparam int COUNT_W     = 12;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	localparam logic [HEIGHT_W-1:0] THRESH_WATER_RST = 16'd15729;
	localparam logic [HEIGHT_W-1:0] THRESH_SAND_RST  = 16'd27525;
	localparam logic [HEIGHT_W-1:0] THRESH_GRASS_RST = 16'd38011;
	localparam logic [HEIGHT_W-1:0] THRESH_ROCK_RST  = 16'd49807;
	localparam logic [CLASS_W-1:0]  TARGET_RST       = 3'd0;
	localparam logic [COUNT_W-1:0]  COUNT_LOW_RST    = 12'd1498;
	localparam logic [COUNT_W-1:0]  COUNT_HIGH_RST   = 12'd1958;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_THRESH_WATER = 3'd0,
		REG_THRESH_SAND  = 3'd1,
		REG_THRESH_GRASS = 3'd2,
		REG_THRESH_ROCK  = 3'd3,
		REG_TARGET_CLASS = 3'd4,
		REG_COUNT_LOW    = 3'd5,
		REG_COUNT_HIGH   = 3'd6
	} cfg_reg_t;

	typedef enum logic [CLASS_W-1:0] {
		CLS_WATER = 3'd0,
		CLS_SAND  = 3'd1,
		CLS_GRASS = 3'd2,
		CLS_ROCK  = 3'd3,
		CLS_SNOW  = 3'd4
	} terrain_cls_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] water;
		logic [HEIGHT_W-1:0] sand;
		logic [HEIGHT_W-1:0] grass;
		logic [HEIGHT_W-1:0] rock;
		logic [CLASS_W-1:0]  target;
	} thr_cfg_t;

	typedef struct packed {
		logic flag;
		logic hist_ok;
		logic cnt_ok;
		logic c_zero;
		logic c_ge_win;
		logic win_valid;
	} ctl_t;

	function automatic int win_of(int patch, int border);
		return (patch > 2 * border) ? (patch - 2 * border) : 1;
	endfunction

endpackage

`default_nettype wire

/* rtl/tcwc_fifo.sv */
`default_nettype none

module tcwc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign full    = (cnt_q == NW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/tcwc_front.sv */
`default_nettype none

module tcwc_front #(
	parameter int IMAGE_SIZE = tcwc_pkg::IMAGE_SIZE_DEF,
	parameter int PATCH_DIM  = tcwc_pkg::PATCH_DIM_DEF,
	parameter int BORDER     = tcwc_pkg::BORDER_DEF,
	localparam int WIN       = tcwc_pkg::win_of(PATCH_DIM, BORDER),
	localparam int PW        = $clog2(IMAGE_SIZE),
	localparam int SW        = (WIN > 1) ? $clog2(WIN) : 1
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic [tcwc_pkg::HEIGHT_W-1:0]    height_sample,
	input  wire logic                             frame_start,
	input  wire tcwc_pkg::thr_cfg_t               cfg,
	output logic [tcwc_pkg::CLASS_W-1:0]          cls,
	output tcwc_pkg::ctl_t                        ctl,
	output logic [PW-1:0]                         col,
	output logic [SW-1:0]                         slot,
	output logic [tcwc_pkg::ORG_W-1:0]            row_org,
	output logic [tcwc_pkg::ORG_W-1:0]            col_org
);
	import tcwc_pkg::*;

	localparam int LAST_OFF    = PATCH_DIM - BORDER - 1;
	localparam int LAST_ORIGIN = IMAGE_SIZE - PATCH_DIM;
	localparam int LAST_END    = LAST_OFF + LAST_ORIGIN;
	localparam bit HAS_WIN     = (LAST_OFF >= 0) && (LAST_ORIGIN >= 0);

	logic [PW-1:0] row_q, col_q, row_c, col_c;
	logic [SW-1:0] slot_q, slot_c;
	int            ri, ci;

	// frame start restarts the position before this pixel
	always_comb begin
		row_c  = frame_start ? '0 : row_q;
		col_c  = frame_start ? '0 : col_q;
		slot_c = frame_start ? '0 : slot_q;
		ri     = int'(row_c);
		ci     = int'(col_c);
	end

	always_comb begin
		if (height_sample < cfg.water) begin
			cls = CLS_WATER;
		end else if (height_sample < cfg.sand) begin
			cls = CLS_SAND;
		end else if (height_sample < cfg.grass) begin
			cls = CLS_GRASS;
		end else if (height_sample < cfg.rock) begin
			cls = CLS_ROCK;
		end else begin
			cls = CLS_SNOW;
		end
	end

	always_comb begin
		ctl.flag      = (cls == cfg.target);
		ctl.hist_ok   = (ri >= WIN);
		ctl.cnt_ok    = (ri != 0);
		ctl.c_zero    = (ci == 0);
		ctl.c_ge_win  = (ci >= WIN);
		ctl.win_valid = HAS_WIN && (ri >= LAST_OFF) && (ri <= LAST_END)
			&& (ci >= LAST_OFF) && (ci <= LAST_END);
		row_org       = ctl.win_valid ? ORG_W'(ri - LAST_OFF) : '0;
		col_org       = ctl.win_valid ? ORG_W'(ci - LAST_OFF) : '0;
		col           = col_c;
		slot          = slot_c;
	end

	// raster position; the pixel after the last one of a frame opens a new frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (ci == IMAGE_SIZE - 1) begin
				col_q <= '0;
				if (ri == IMAGE_SIZE - 1) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_c + 1'b1;
					slot_q <= (int'(slot_c) == WIN - 1) ? '0 : slot_c + 1'b1;
				end
			end else begin
				col_q  <= col_c + 1'b1;
				row_q  <= row_c;
				slot_q <= slot_c;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/tcwc_back.sv */
`default_nettype none

module tcwc_back #(
	parameter int IMAGE_SIZE = tcwc_pkg::IMAGE_SIZE_DEF,
	parameter int PATCH_DIM  = tcwc_pkg::PATCH_DIM_DEF,
	parameter int BORDER     = tcwc_pkg::BORDER_DEF,
	localparam int WIN       = tcwc_pkg::win_of(PATCH_DIM, BORDER),
	localparam int PW        = $clog2(IMAGE_SIZE),
	localparam int SW        = (WIN > 1) ? $clog2(WIN) : 1
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             q_empty,
	output logic                                  q_pop,
	input  wire logic [tcwc_pkg::CLASS_W-1:0]     in_cls,
	input  wire tcwc_pkg::ctl_t                   in_ctl,
	input  wire logic [PW-1:0]                    in_col,
	input  wire logic [SW-1:0]                    in_slot,
	input  wire logic [tcwc_pkg::ORG_W-1:0]       in_row_org,
	input  wire logic [tcwc_pkg::ORG_W-1:0]       in_col_org,
	input  wire logic [tcwc_pkg::COUNT_W-1:0]     count_low,
	input  wire logic [tcwc_pkg::COUNT_W-1:0]     count_high,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [tcwc_pkg::CLASS_W-1:0]          pixel_class,
	output logic                                  window_valid,
	output logic [tcwc_pkg::ORG_W-1:0]            window_row,
	output logic [tcwc_pkg::ORG_W-1:0]            window_col,
	output logic [tcwc_pkg::COUNT_W-1:0]          window_count,
	output logic                                  in_band
);
	import tcwc_pkg::*;

	localparam int CW = $clog2(WIN + 1);

	// per column: count in the upper bits, history flags of the last WIN rows below
	logic [CW+WIN-1:0]  col_mem [IMAGE_SIZE];
	logic [CW+WIN-1:0]  rd_s1;

	logic               valid_s1, valid_s2;
	logic [CLASS_W-1:0] cls_s1;
	ctl_t               ctl_s1;
	logic [PW-1:0]      col_s1;
	logic [SW-1:0]      slot_s1;
	logic [ORG_W-1:0]   row_org_s1, col_org_s1;

	logic [CW-1:0]      sl_q [WIN];
	logic [COUNT_W-1:0] sum_q;

	logic               s1_free, s2_load;
	logic [WIN-1:0]     old_hist, hist_new;
	logic [CW-1:0]      old_cnt, cnt_new, sub_cnt;
	logic               old_bit;
	logic [COUNT_W-1:0] base_sum, sum_new;
	logic               band_ok;

	assign s2_load = valid_s1 && (!valid_s2 || pop);
	assign s1_free = !valid_s1 || s2_load;
	assign q_pop   = !q_empty && s1_free;
	assign empty   = !valid_s2;

	// rows not yet seen in this frame read as zero
	always_comb begin
		old_hist          = rd_s1[WIN-1:0];
		old_cnt           = ctl_s1.cnt_ok ? rd_s1[CW+WIN-1:WIN] : '0;
		old_bit           = ctl_s1.hist_ok && old_hist[slot_s1];
		cnt_new           = old_cnt + CW'(ctl_s1.flag) - CW'(old_bit);
		hist_new          = old_hist;
		hist_new[slot_s1] = ctl_s1.flag;
		sub_cnt           = ctl_s1.c_ge_win ? sl_q[WIN-1] : '0;
		base_sum          = ctl_s1.c_zero ? '0 : sum_q;
		sum_new           = base_sum + COUNT_W'(cnt_new) - COUNT_W'(sub_cnt);
		band_ok           = (sum_new >= count_low) && (sum_new <= count_high);
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			col_mem[col_s1] <= {cnt_new, hist_new};
		end
		if (q_pop) begin
			rd_s1 <= col_mem[in_col];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cls_s1     <= in_cls;
			ctl_s1     <= in_ctl;
			col_s1     <= in_col;
			slot_s1    <= in_slot;
			row_org_s1 <= in_row_org;
			col_org_s1 <= in_col_org;
		end
	end

	// column counts of the current row, newest first
	always_ff @(posedge clk) begin
		if (s2_load) begin
			sl_q[0] <= cnt_new;
			for (int i = 1; i < WIN; i++) begin
				sl_q[i] <= sl_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			pixel_class  <= cls_s1;
			window_valid <= ctl_s1.win_valid;
			window_row   <= row_org_s1;
			window_col   <= col_org_s1;
			window_count <= ctl_s1.win_valid ? sum_new : '0;
			in_band      <= ctl_s1.win_valid && band_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sum_q    <= '0;
		end else begin
			if (s1_free) begin
				valid_s1 <= q_pop;
			end
			if (s2_load) begin
				valid_s2 <= 1'b1;
				sum_q    <= sum_new;
			end else if (pop) begin
				valid_s2 <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/terrain_class_window_count.sv */
`default_nettype none

// Terrain class window counter. Takes one height sample per cycle while full is low,
// in raster order, and returns one result per sample, in order: the pixel's terrain
// class and, when the pixel closes the inner window of a patch, the patch origin,
// the window's target-class count and the band flag. Sustained rate is one sample
// per cycle while pop keeps up; that figure is set by the per-column store (IMAGE_SIZE
// words holding the last WIN target flags and their count), which takes one read and
// one write each cycle for the read-modify-write of the current column. A four-entry
// queue sits between classification and the counting pipeline, so push keeps being
// taken while a result waits for pop, until the queue fills. The stores need no
// clearing pass: the row and column positions mask entries not yet written in the
// current frame. The user must write thresholds, target class and band through the
// cfg port only while no transaction is in flight; the block does not enforce it.
module terrain_class_window_count #(
	parameter int IMAGE_SIZE = tcwc_pkg::IMAGE_SIZE_DEF,
	parameter int PATCH_DIM  = tcwc_pkg::PATCH_DIM_DEF,
	parameter int BORDER     = tcwc_pkg::BORDER_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tcwc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tcwc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [tcwc_pkg::HEIGHT_W-1:0]    height_sample,
	input  wire logic                             frame_start,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [tcwc_pkg::CLASS_W-1:0]          pixel_class,
	output logic                                  window_valid,
	output logic [tcwc_pkg::ORG_W-1:0]            window_row,
	output logic [tcwc_pkg::ORG_W-1:0]            window_col,
	output logic [tcwc_pkg::COUNT_W-1:0]          window_count,
	output logic                                  in_band
);
	import tcwc_pkg::*;

	localparam int WIN = win_of(PATCH_DIM, BORDER);
	localparam int PW  = $clog2(IMAGE_SIZE);
	localparam int SW  = (WIN > 1) ? $clog2(WIN) : 1;
	localparam int EW  = $bits(ctl_t) + CLASS_W + PW + SW + 2 * ORG_W;

	thr_cfg_t           thr_q;
	logic [COUNT_W-1:0] count_low_q, count_high_q;

	logic               accept;
	logic [CLASS_W-1:0] f_cls, b_cls;
	ctl_t               f_ctl, b_ctl;
	logic [PW-1:0]      f_col, b_col;
	logic [SW-1:0]      f_slot, b_slot;
	logic [ORG_W-1:0]   f_row_org, f_col_org, b_row_org, b_col_org;
	logic [EW-1:0]      q_din, q_dout;
	logic               q_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.water  <= THRESH_WATER_RST;
			thr_q.sand   <= THRESH_SAND_RST;
			thr_q.grass  <= THRESH_GRASS_RST;
			thr_q.rock   <= THRESH_ROCK_RST;
			thr_q.target <= TARGET_RST;
			count_low_q  <= COUNT_LOW_RST;
			count_high_q <= COUNT_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESH_WATER: thr_q.water  <= cfg_data;
				REG_THRESH_SAND:  thr_q.sand   <= cfg_data;
				REG_THRESH_GRASS: thr_q.grass  <= cfg_data;
				REG_THRESH_ROCK:  thr_q.rock   <= cfg_data;
				REG_TARGET_CLASS: thr_q.target <= cfg_data[CLASS_W-1:0];
				REG_COUNT_LOW:    count_low_q  <= cfg_data[COUNT_W-1:0];
				REG_COUNT_HIGH:   count_high_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign accept = push && !full;

	tcwc_front #(
		.IMAGE_SIZE (IMAGE_SIZE),
		.PATCH_DIM  (PATCH_DIM),
		.BORDER     (BORDER)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.height_sample (height_sample),
		.frame_start   (frame_start),
		.cfg           (thr_q),
		.cls           (f_cls),
		.ctl           (f_ctl),
		.col           (f_col),
		.slot          (f_slot),
		.row_org       (f_row_org),
		.col_org       (f_col_org)
	);

	assign q_din = {f_ctl, f_cls, f_col, f_slot, f_row_org, f_col_org};
	assign {b_ctl, b_cls, b_col, b_slot, b_row_org, b_col_org} = q_dout;

	tcwc_fifo #(
		.WIDTH (EW),
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (q_din),
		.full   (full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	tcwc_back #(
		.IMAGE_SIZE (IMAGE_SIZE),
		.PATCH_DIM  (PATCH_DIM),
		.BORDER     (BORDER)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.in_cls       (b_cls),
		.in_ctl       (b_ctl),
		.in_col       (b_col),
		.in_slot      (b_slot),
		.in_row_org   (b_row_org),
		.in_col_org   (b_col_org),
		.count_low    (count_low_q),
		.count_high   (count_high_q),
		.empty        (empty),
		.pop          (pop),
		.pixel_class  (pixel_class),
		.window_valid (window_valid),
		.window_row   (window_row),
		.window_col   (window_col),
		.window_count (window_count),
		.in_band      (in_band)
	);

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
	import tcwc_pkg::*;

	localparam int IMG      = IMAGE_SIZE_DEF;
	localparam int PATCH    = PATCH_DIM_DEF;
	localparam int BORD     = BORDER_DEF;
	localparam int WIN_W    = (PATCH > 2 * BORD) ? (PATCH - 2 * BORD) : 1;
	localparam int LAST_OFF = PATCH - BORD - 1;
	localparam int LAST_ORG = IMG - PATCH;
	localparam int LIMIT    = 4000000;

	typedef struct {
		terrain_cls_t       cls;
		logic               wv;
		logic [ORG_W-1:0]   wrow;
		logic [ORG_W-1:0]   wcol;
		logic [COUNT_W-1:0] cnt;
		logic               band;
	} pix_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   push = 1'b0;
	logic                   full;
	logic [HEIGHT_W-1:0]    height_sample = '0;
	logic                   frame_start = 1'b0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic [CLASS_W-1:0]     pixel_class;
	logic                   window_valid;
	logic [ORG_W-1:0]       window_row;
	logic [ORG_W-1:0]       window_col;
	logic [COUNT_W-1:0]     window_count;
	logic                   in_band;

	terrain_class_window_count dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.height_sample(height_sample),
		.frame_start(frame_start),
		.empty(empty),
		.pop(pop),
		.pixel_class(pixel_class),
		.window_valid(window_valid),
		.window_row(window_row),
		.window_col(window_col),
		.window_count(window_count),
		.in_band(in_band)
	);

	always #10 clk = ~clk;

	// shadow configuration
	logic [HEIGHT_W-1:0] thr [4] = '{THRESH_WATER_RST, THRESH_SAND_RST,
		THRESH_GRASS_RST, THRESH_ROCK_RST};
	logic [CLASS_W-1:0]  cfg_target = TARGET_RST;
	logic [COUNT_W-1:0]  cfg_low = COUNT_LOW_RST;
	logic [COUNT_W-1:0]  cfg_high = COUNT_HIGH_RST;

	// shadow window state
	bit [WIN_W-1:0] col_hist [IMG];
	int             col_cnt [IMG];
	int             recent_cnt [WIN_W];
	int             win_sum = 0;
	int             row_pos = 0;
	int             col_pos = 0;

	pix_result_t expected_px [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int mismatches = 0;
	int n_items = 0;
	int n_results = 0;
	int n_windows = 0;
	int n_in_band = 0;
	int cycles = 0;

	function automatic pix_result_t predict_pixel(logic [HEIGHT_W-1:0] h, logic fs);
		pix_result_t res;
		int r, c, slot, ring, cnt;
		bit flag, old;
		if (fs || row_pos >= IMG || col_pos >= IMG) begin
			for (int i = 0; i < IMG; i++) begin
				col_hist[i] = '0;
				col_cnt[i] = 0;
			end
			for (int i = 0; i < WIN_W; i++)
				recent_cnt[i] = 0;
			win_sum = 0;
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		res.cls = CLS_SNOW;
		for (int k = 3; k >= 0; k--)
			if (h < thr[k])
				res.cls = terrain_cls_t'(k);
		flag = (CLASS_W'(res.cls) == cfg_target);
		slot = r % WIN_W;
		old = col_hist[c][slot];
		col_hist[c][slot] = flag;
		cnt = col_cnt[c] + int'(flag) - int'(old);
		col_cnt[c] = cnt;
		if (c == 0) begin
			for (int i = 0; i < WIN_W; i++)
				recent_cnt[i] = 0;
			win_sum = 0;
		end
		ring = c % WIN_W;
		win_sum = win_sum + cnt - recent_cnt[ring];
		recent_cnt[ring] = cnt;
		if (r >= LAST_OFF && c >= LAST_OFF && r - LAST_OFF <= LAST_ORG &&
			c - LAST_OFF <= LAST_ORG && LAST_ORG >= 0) begin
			res.wv = 1'b1;
			res.wrow = ORG_W'(r - LAST_OFF);
			res.wcol = ORG_W'(c - LAST_OFF);
			res.cnt = COUNT_W'(win_sum);
			res.band = (res.cnt >= cfg_low) && (res.cnt <= cfg_high);
		end else begin
			res.wv = 1'b0;
			res.wrow = '0;
			res.wcol = '0;
			res.cnt = '0;
			res.band = 1'b0;
		end
		col_pos = c + 1;
		if (col_pos >= IMG) begin
			col_pos = 0;
			row_pos = r + 1;
		end
		return res;
	endfunction

	// a height that falls in class k under ordered thresholds, else any height
	function automatic logic [HEIGHT_W-1:0] height_in_class(int k);
		int unsigned lo, hi;
		lo = 0;
		hi = 65536;
		if (k > 0)
			lo = thr[k-1];
		if (k < 4)
			hi = thr[k];
		if (hi > lo)
			return HEIGHT_W'(lo + $urandom_range(0, hi - lo - 1));
		return HEIGHT_W'($urandom);
	endfunction

	task automatic send_pixel(logic [HEIGHT_W-1:0] h, logic fs);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		height_sample <= h;
		frame_start <= fs;
		@(posedge clk);
		while (full)
			@(posedge clk);
		expected_px.insert(expected_px.size(), predict_pixel(h, fs));
		n_items++;
	endtask

	task automatic drain_pipeline();
		push <= 1'b0;
		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_THRESH_WATER, REG_THRESH_SAND, REG_THRESH_GRASS, REG_THRESH_ROCK:
				thr[int'(idx)] = val[HEIGHT_W-1:0];
			REG_TARGET_CLASS: cfg_target = val[CLASS_W-1:0];
			REG_COUNT_LOW:    cfg_low = val[COUNT_W-1:0];
			REG_COUNT_HIGH:   cfg_high = val[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int unsigned w, int unsigned s, int unsigned g, int unsigned rk,
		int unsigned tg, int unsigned lo, int unsigned hi);
		write_reg(REG_THRESH_WATER, w);
		write_reg(REG_THRESH_SAND, s);
		write_reg(REG_THRESH_GRASS, g);
		write_reg(REG_THRESH_ROCK, rk);
		write_reg(REG_TARGET_CLASS, tg);
		write_reg(REG_COUNT_LOW, lo);
		write_reg(REG_COUNT_HIGH, hi);
	endtask

	task automatic set_idle(int phase);
		case (phase)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
			default: begin send_idle_pct = 23; recv_stall_pct = 23; end
		endcase
	endtask

	// class regions of 80 rows by 64 columns, some pure, some noisy
	task automatic stream_frame(int npix, int shift);
		int r, c, rb, cb, noise;
		logic [HEIGHT_W-1:0] h;
		for (int k = 0; k < npix; k++) begin
			r = k / IMG;
			c = k % IMG;
			rb = r / 80;
			cb = c / 64;
			noise = ((rb * 3 + cb) % 4) * 33;
			if ($urandom_range(0, 99) < noise)
				h = HEIGHT_W'($urandom);
			else
				h = height_in_class((rb + cb + shift) % 5);
			send_pixel(h, k == 0);
		end
	endtask

	task automatic test_class_boundaries();
		logic [HEIGHT_W-1:0] hv [10] = '{16'd0, 16'd65535, 16'd15728, 16'd15729,
			16'd27524, 16'd27525, 16'd38010, 16'd38011, 16'd49806, 16'd49807};
		set_idle(0);
		foreach (hv[i])
			send_pixel(hv[i], i == 0);
		send_pixel(16'd20000, 1'b1);
		send_pixel(16'd60000, 1'b0);
	endtask

	task automatic test_config_corners();
		logic [HEIGHT_W-1:0] hv [8] = '{16'd0, 16'd9999, 16'd10000, 16'd39999,
			16'd40000, 16'd49999, 16'd50000, 16'd65535};
		drain_pipeline();
		// thresholds out of order, unmatched target, inverted band
		set_config(40000, 10000, 50000, 0, 7, 2304, 0);
		foreach (hv[i])
			send_pixel(hv[i], 1'b0);
		drain_pipeline();
		set_config(0, 0, 0, 0, CLS_SNOW, 0, 2304);
		send_pixel(16'd0, 1'b0);
		send_pixel(16'd65535, 1'b0);
		drain_pipeline();
		set_config(65535, 65535, 65535, 65535, CLS_WATER, 0, 0);
		send_pixel(16'd65534, 1'b0);
		send_pixel(16'd65535, 1'b0);
	endtask

	task automatic test_backpressure();
		drain_pipeline();
		set_config(THRESH_WATER_RST, THRESH_SAND_RST, THRESH_GRASS_RST, THRESH_ROCK_RST,
			CLS_GRASS, COUNT_LOW_RST, COUNT_HIGH_RST);
		set_idle(0);
		hold_len = 300;
		hold_token++;
		for (int k = 0; k < 200; k++)
			send_pixel(HEIGHT_W'($urandom), k == 0);
		drain_pipeline();
	endtask

	task automatic test_row_crossing();
		int unsigned lo;
		drain_pipeline();
		lo = $urandom_range(0, 1152);
		set_config(THRESH_WATER_RST, THRESH_SAND_RST, THRESH_GRASS_RST, THRESH_ROCK_RST,
			$urandom_range(0, 4), lo, lo + $urandom_range(0, 1152));
		set_idle(0);
		stream_frame(IMG + $urandom_range(40, 80), $urandom_range(0, 4));
		// frame start in the middle of a row
		stream_frame($urandom_range(20, 40), $urandom_range(0, 4));
	endtask

	task automatic test_window_phases();
		int unsigned tq [$];
		int tg;
		for (int ph = 0; ph < 4; ph++) begin
			drain_pipeline();
			tq.delete();
			repeat (4) tq.insert(tq.size(), $urandom_range(0, 65535));
			tq.sort();
			case (ph)
				0: begin
					tg = CLS_WATER;
					set_config(THRESH_WATER_RST, THRESH_SAND_RST, THRESH_GRASS_RST,
						THRESH_ROCK_RST, tg, 0, 0);
				end
				1: begin
					tg = $urandom_range(0, 4);
					set_config(tq[0], tq[1], tq[2], tq[3], tg, 2304, 2304);
				end
				2: begin
					tg = CLS_SNOW;
					set_config(tq[0], tq[1], tq[2], tq[3], tg, 2304, 0);
				end
				default: begin
					tg = 7;
					set_config(tq[0], tq[1], tq[2], tq[3], tg, $urandom_range(0, 10), 2304);
				end
			endcase
			set_idle(ph);
			stream_frame($urandom_range(100, 140), (tg + 1) % 5);
		end
	endtask

	task automatic test_random_mix();
		int unsigned tq [$];
		int unsigned lo, hi, len, pick;
		int burst;
		logic [HEIGHT_W-1:0] h;
		burst = 0;
		while (n_items < 1850) begin
			if (burst % 3 == 0) begin
				drain_pipeline();
				tq.delete();
				repeat (4) begin
					pick = $urandom_range(0, 9);
					tq.insert(tq.size(),
						pick == 0 ? 0 : (pick == 1 ? 65535 : $urandom_range(0, 65535)));
				end
				if ($urandom_range(0, 1))
					tq.sort();
				lo = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(0, 2304);
				hi = $urandom_range(0, 9) == 0 ? 2304 : $urandom_range(0, 2304);
				set_config(tq[0], tq[1], tq[2], tq[3], $urandom_range(0, 7), lo, hi);
			end
			set_idle(burst % 4);
			len = $urandom_range(10, 150);
			repeat (len) begin
				if ($urandom_range(0, 1))
					h = HEIGHT_W'($urandom);
				else
					h = height_in_class($urandom_range(0, 4));
				send_pixel(h, $urandom_range(0, 99) < 3);
			end
			burst++;
		end
	endtask

	always @(posedge clk) begin : result_check
		pix_result_t exp_r;
		logic bad;
		if (arst_n && pop && !empty) begin
			if (expected_px.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: class %0d valid %0d row %0d col %0d count %0d",
						pixel_class, window_valid, window_row, window_col, window_count);
			end else begin
				exp_r = expected_px.pop_front();
				bad = (pixel_class !== exp_r.cls) || (window_valid !== exp_r.wv) ||
					(window_row !== exp_r.wrow) || (window_col !== exp_r.wcol) ||
					(window_count !== exp_r.cnt) || (in_band !== exp_r.band);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at result %0d (exp/got): class %0d/%0d valid %0d/%0d",
							" row %0d/%0d col %0d/%0d count %0d/%0d band %0d/%0d"},
							n_results, exp_r.cls, pixel_class, exp_r.wv, window_valid,
							exp_r.wrow, window_row, exp_r.wcol, window_col,
							exp_r.cnt, window_count, exp_r.band, in_band);
				end
				n_results++;
				if (exp_r.wv)
					n_windows++;
				if (exp_r.band)
					n_in_band++;
			end
		end
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = hold_len;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_px.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_class_boundaries();
		test_config_corners();
		test_backpressure();
		test_row_crossing();
		test_window_phases();
		test_random_mix();
		drain_pipeline();
		$display("%0d pixels sent, %0d results checked, %0d closing a window (%0d in band)",
			n_items, n_results, n_windows, n_in_band);
		$display("threshold edges and disorder, band extremes, row crossing and frame restart,");
		$display("full-queue stall, idle and stall phases");
		if (mismatches == 0 && expected_px.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
